// ----- design/jia_pkg.sv -----
// shared types, op codes and helpers of the jvm integer/long alu
package jia_pkg;

    localparam logic [4:0] OP_IADD  = 5'd0;
    localparam logic [4:0] OP_ISUB  = 5'd1;
    localparam logic [4:0] OP_IMUL  = 5'd2;
    localparam logic [4:0] OP_IDIV  = 5'd3;
    localparam logic [4:0] OP_IAND  = 5'd4;
    localparam logic [4:0] OP_IOR   = 5'd5;
    localparam logic [4:0] OP_IXOR  = 5'd6;
    localparam logic [4:0] OP_ISHL  = 5'd7;
    localparam logic [4:0] OP_ISHR  = 5'd8;
    localparam logic [4:0] OP_IUSHR = 5'd9;
    localparam logic [4:0] OP_INEG  = 5'd10;
    localparam logic [4:0] OP_I2B   = 5'd11;
    localparam logic [4:0] OP_I2C   = 5'd12;
    localparam logic [4:0] OP_I2S   = 5'd13;
    localparam logic [4:0] OP_I2L   = 5'd14;
    localparam logic [4:0] OP_L2I   = 5'd15;
    localparam logic [4:0] OP_LADD  = 5'd16;
    localparam logic [4:0] OP_LSUB  = 5'd17;
    localparam logic [4:0] OP_LMUL  = 5'd18;
    localparam logic [4:0] OP_LDIV  = 5'd19;
    localparam logic [4:0] OP_LAND  = 5'd20;
    localparam logic [4:0] OP_LOR   = 5'd21;
    localparam logic [4:0] OP_LXOR  = 5'd22;
    localparam logic [4:0] OP_LSHL  = 5'd23;
    localparam logic [4:0] OP_LSHR  = 5'd24;
    localparam logic [4:0] OP_LUSHR = 5'd25;
    localparam logic [4:0] OP_LNEG  = 5'd26;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_TYPE = 2'd1;
    localparam logic [1:0] ERR_DIV0 = 2'd2;

    localparam logic [4:0] MASK5 = 5'h1F;
    localparam logic [5:0] MASK6 = 6'h3F;

    localparam int DIV_STEPS = 64;

    typedef enum logic [2:0]
    {
        KIND_SIMPLE = 3'b001,
        KIND_MUL    = 3'b010,
        KIND_DIV    = 3'b100
    } kind_t;

    // decode stage contents
    typedef struct packed
    {
        kind_t       kind;
        logic [1:0]  err;
        logic        is_int;
        logic [63:0] res;
        logic [63:0] p_ll;
        logic [31:0] p_lh;
        logic [31:0] p_hl;
        logic        neg_q;
        logic [63:0] dvd;
        logic [63:0] dsr;
    } front_t;

    // divider stage contents
    typedef struct packed
    {
        kind_t       kind;
        logic [1:0]  err;
        logic        is_int;
        logic [63:0] res;
        logic        neg_q;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] dsr;
    } pipe_t;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // one restoring division step: shift in one dividend bit, subtract if it fits
    function automatic pipe_t div_step(input pipe_t p);
        pipe_t       n;
        logic [63:0] rs;
        n  = p;
        rs = {p.rem[62:0], p.quo[63]};
        n.quo = {p.quo[62:0], 1'b0};
        if (rs >= p.dsr)
        begin
            rs       = rs - p.dsr;
            n.quo[0] = 1'b1;
        end
        n.rem = rs;
        return n;
    endfunction

endpackage

// ----- design/jia_in_if.sv -----
// request channel: one bytecode with operands and type tags
interface jia_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         op;
    logic signed [63:0] first_operand;
    logic signed [63:0] second_operand;
    logic               first_is_numeric;
    logic               second_is_numeric;

    modport source (output valid, op, first_operand, second_operand,
                    first_is_numeric, second_is_numeric, input ready);
    modport sink   (input valid, op, first_operand, second_operand,
                    first_is_numeric, second_is_numeric, output ready);
endinterface

// ----- design/jia_out_if.sv -----
// response channel: result value and error code
interface jia_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] result_value;
    logic [1:0]         error_code;

    modport source (output valid, result_value, error_code, input ready);
    modport sink   (input valid, result_value, error_code, output ready);
endinterface

// ----- design/jia_decode.sv -----
// decode, error checks, simple ops, partial products and divider operand setup
module jia_decode
(
    input  logic [4:0]      op,
    input  logic [63:0]     a,
    input  logic [63:0]     b,
    input  logic            a_num,
    input  logic            b_num,
    output jia_pkg::front_t fr
);
    import jia_pkg::*;

    logic        unary;
    logic        type_err;
    logic        div0;
    logic [63:0] a32;
    logic [63:0] b32;
    logic [4:0]  s5;
    logic [5:0]  s6;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] lh_full;
    logic [63:0] hl_full;

    assign a32 = sx32(a[31:0]);
    assign b32 = sx32(b[31:0]);
    assign s5  = b[4:0] & MASK5;
    assign s6  = b[5:0] & MASK6;

    assign unary    = (op == OP_INEG) || ((op >= OP_I2B) && (op <= OP_L2I)) || (op == OP_LNEG);
    assign type_err = (op <= OP_LNEG) && (!a_num || (!unary && !b_num));
    assign div0     = ((op == OP_IDIV) && (b[31:0] == 32'd0))
                   || ((op == OP_LDIV) && (b == 64'd0));

    assign x = (op == OP_IDIV) ? a32 : a;
    assign y = (op == OP_IDIV) ? b32 : b;

    assign lh_full = 64'(a[31:0]) * 64'(b[63:32]);
    assign hl_full = 64'(a[63:32]) * 64'(b[31:0]);

    always_comb
    begin
        fr        = '0;
        fr.kind   = KIND_SIMPLE;
        fr.is_int = (op == OP_IMUL) || (op == OP_IDIV);
        fr.p_ll   = 64'(a[31:0]) * 64'(b[31:0]);
        fr.p_lh   = lh_full[31:0];
        fr.p_hl   = hl_full[31:0];
        fr.neg_q  = x[63] ^ y[63];
        fr.dvd    = x[63] ? (64'd0 - x) : x;
        fr.dsr    = y[63] ? (64'd0 - y) : y;
        fr.err    = type_err ? ERR_TYPE : (div0 ? ERR_DIV0 : ERR_NONE);
        case (op)
            OP_IADD:  fr.res = sx32(a[31:0] + b[31:0]);
            OP_ISUB:  fr.res = sx32(a[31:0] - b[31:0]);
            OP_IMUL:  fr.kind = KIND_MUL;
            OP_IDIV:  fr.kind = KIND_DIV;
            OP_IAND:  fr.res = a32 & b32;
            OP_IOR:   fr.res = a32 | b32;
            OP_IXOR:  fr.res = a32 ^ b32;
            OP_ISHL:  fr.res = sx32(a[31:0] << s5);
            OP_ISHR:  fr.res = sx32(32'($signed(a[31:0]) >>> s5));
            OP_IUSHR: fr.res = sx32(a[31:0] >> s5);
            OP_INEG:  fr.res = sx32(32'd0 - a[31:0]);
            OP_I2B:   fr.res = {{56{a[7]}}, a[7:0]};
            OP_I2C:   fr.res = {48'd0, a[15:0]};
            OP_I2S:   fr.res = {{48{a[15]}}, a[15:0]};
            OP_I2L:   fr.res = a32;
            OP_L2I:   fr.res = a32;
            OP_LADD:  fr.res = a + b;
            OP_LSUB:  fr.res = a - b;
            OP_LMUL:  fr.kind = KIND_MUL;
            OP_LDIV:  fr.kind = KIND_DIV;
            OP_LAND:  fr.res = a & b;
            OP_LOR:   fr.res = a | b;
            OP_LXOR:  fr.res = a ^ b;
            OP_LSHL:  fr.res = a << s6;
            OP_LSHR:  fr.res = 64'($signed(a) >>> s6);
            OP_LUSHR: fr.res = a >> s6;
            OP_LNEG:  fr.res = 64'd0 - a;
            default:  fr.res = 64'd0;
        endcase
    end
endmodule

// ----- design/jvm_int_long_alu.sv -----
// top level of the jvm integer/long alu: 66-stage pipeline with elastic stall
//
//  channel | dir | fields
//  --------+-----+---------------------------------------------------------------
//  req     | in  | op, first_operand, second_operand, first_is_numeric,
//          |     | second_is_numeric
//  rsp     | out | result_value, error_code
//
// every op passes through every stage from request to response; one item enters per
// cycle unless stalled; stages: radix-2 divider, one quotient bit per stage (64 stages),
// plus a decode stage and an output register; all ops travel the same path so order holds
// reset clears only the stage valid bits
// a stage advances when the stage after it is empty or advancing, so bubbles close up
// while the output waits and nothing is lost or repeated
module jvm_int_long_alu
(
    input  logic      clk,
    input  logic      rst_n,
    jia_in_if.sink    req,
    jia_out_if.source rsp
);
    import jia_pkg::*;

    localparam int NSTG = DIV_STEPS + 2;

    // stage valid bits: 0 decode, 1..DIV_STEPS divider, NSTG-1 output
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    front_t          front_reg;
    front_t          front_next;
    pipe_t           pipe_reg [DIV_STEPS];
    pipe_t           pipe_first;
    logic [63:0]     res_reg;
    logic [63:0]     res_next;
    logic [1:0]      err_reg;
    logic [1:0]      err_next;

    logic [31:0]     mid_sum;
    logic [63:0]     quo_s;

    jia_decode u_decode
    (
        .op    (req.op),
        .a     (req.first_operand),
        .b     (req.second_operand),
        .a_num (req.first_is_numeric),
        .b_num (req.second_is_numeric),
        .fr    (front_next)
    );

    // stall chain from the output back to the request
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || rsp.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign req.ready = en[0];

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = req.valid;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // first divider stage also folds the partial products into the multiply result
    assign mid_sum = front_reg.p_lh + front_reg.p_hl;

    always_comb
    begin
        pipe_t p;
        p.kind   = front_reg.kind;
        p.err    = front_reg.err;
        p.is_int = front_reg.is_int;
        p.neg_q  = front_reg.neg_q;
        p.rem    = 64'd0;
        p.quo    = front_reg.dvd;
        p.dsr    = front_reg.dsr;
        p.res    = front_reg.res;
        if (front_reg.kind == KIND_MUL)
        begin
            p.res = front_reg.is_int ? sx32(front_reg.p_ll[31:0])
                                     : front_reg.p_ll + {mid_sum, 32'd0};
        end
        pipe_first = div_step(p);
    end

    // final quotient sign fix and result select
    assign quo_s = pipe_reg[DIV_STEPS-1].neg_q ? (64'd0 - pipe_reg[DIV_STEPS-1].quo)
                                               : pipe_reg[DIV_STEPS-1].quo;

    always_comb
    begin
        err_next = pipe_reg[DIV_STEPS-1].err;
        if (pipe_reg[DIV_STEPS-1].err != ERR_NONE)
        begin
            res_next = 64'd0;
        end
        else if (pipe_reg[DIV_STEPS-1].kind == KIND_DIV)
        begin
            res_next = pipe_reg[DIV_STEPS-1].is_int ? sx32(quo_s[31:0]) : quo_s;
        end
        else
        begin
            res_next = pipe_reg[DIV_STEPS-1].res;
        end
    end

    // payload registers, loaded whenever their stage advances
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            front_reg <= front_next;
        end
        if (en[1])
        begin
            pipe_reg[0] <= pipe_first;
        end
        for (int i = 1; i < DIV_STEPS; i++)
        begin
            if (en[i+1])
            begin
                pipe_reg[i] <= div_step(pipe_reg[i-1]);
            end
        end
        if (en[NSTG-1])
        begin
            res_reg <= res_next;
            err_reg <= err_next;
        end
    end

    assign rsp.valid        = vld_reg[NSTG-1];
    assign rsp.result_value = res_reg;
    assign rsp.error_code   = err_reg;
endmodule

// ----- design/jia_checker.sv -----
// port-level checks of the jvm integer/long alu and their bind
module jia_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] result_value,
    input logic [1:0]  error_code
);
    import jia_pkg::*;

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value) && $stable(error_code))
        else $error("stalled response changed");

    // any error comes with a zero result
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && error_code != ERR_NONE |-> result_value == 64'd0)
        else $error("error response with nonzero result");

    // only defined error codes
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> error_code == ERR_NONE || error_code == ERR_TYPE
                   || error_code == ERR_DIV0)
        else $error("undefined error code");

    // the request side only stalls behind a waiting response
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request stalled without a waiting response");
endmodule

bind jvm_int_long_alu jia_checker u_jia_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_value (rsp.result_value),
    .error_code   (rsp.error_code)
);
